/* src/rational_function_evaluator_unit_defines.svh */
// Assertion macros shared by the evaluator
`ifndef RATIONAL_FUNCTION_EVALUATOR_UNIT_DEFINES_SVH
`define RATIONAL_FUNCTION_EVALUATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfe assertion failed");

// next-cycle implication
`define RFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfe assertion failed");

`endif

/* src/rfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rfe_pkg;
    localparam int VAL_W           = 32;
    localparam int COEF_REGS       = 3;
    localparam int IDX_W           = 3;
    localparam int TERMS_W         = 2;
    localparam int LIMIT_W         = 15;
    localparam int DEF_MAX_TERMS   = 3;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_RATIO_LIMIT = 32767;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISSING   = 3'd1,
        ST_POLE      = 3'd2,
        ST_ZERO_ZERO = 3'd3,
        ST_LARGE     = 3'd4
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_NUM_TERMS = 3'd0,
        REG_DEN_TERMS = 3'd1,
        REG_NUM_C0    = 3'd2,
        REG_NUM_C1    = 3'd3,
        REG_NUM_C2    = 3'd4,
        REG_DEN_C0    = 3'd5,
        REG_DEN_C1    = 3'd6,
        REG_DEN_C2    = 3'd7
    } cfg_idx_t;

    typedef logic [COEF_REGS-1:0][VAL_W-1:0] coef_vec_t;

    typedef struct packed {
        logic    done;
        logic    missing;
        status_t status;
        logic    neg;
    } side_t;
endpackage
`default_nettype wire

/* src/rfe_horner.sv */
`timescale 1ns / 1ps
`default_nettype none
module rfe_horner
    import rfe_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [VAL_W-1:0]   x,
    input  wire coef_vec_t                 coef,
    input  wire logic [TERMS_W-1:0]        n_eff,
    output logic signed [VAL_W-1:0]        val,
    output logic                           ovf
);
    localparam int STEPS = COEF_REGS - 1;
    localparam logic signed [2*VAL_W-1:0] HALF = (2*VAL_W)'(1) << (FRAC_BITS - 1);
    localparam logic signed [VAL_W-1:0]   ONE  = VAL_W'(1) << FRAC_BITS;

    logic signed [VAL_W-1:0]   a_t_reg [STEPS];
    logic signed [VAL_W-1:0]   a_x_reg [STEPS];
    logic                      a_ovf_reg [STEPS];
    logic signed [2*VAL_W-1:0] b_p_reg [STEPS];
    logic signed [VAL_W-1:0]   b_x_reg [STEPS];
    logic                      b_ovf_reg [STEPS];
    logic signed [VAL_W-1:0]   c_t_reg [STEPS];
    logic signed [VAL_W-1:0]   c_x_reg [STEPS];
    logic                      c_ovf_reg [STEPS];
    logic signed [VAL_W-1:0]   val_reg;
    logic                      ovf_reg;

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int J = COEF_REGS - 1 - s;
        logic signed [VAL_W-1:0]   t_in;
        logic signed [VAL_W-1:0]   x_in;
        logic                      ovf_in;
        logic signed [VAL_W-1:0]   csel;
        logic signed [VAL_W:0]     sum;
        logic signed [2*VAL_W-1:0] rs;

        if (s == 0) begin : g_first
            assign t_in   = '0;
            assign x_in   = x;
            assign ovf_in = 1'b0;
        end
        else begin : g_next
            assign t_in   = c_t_reg[s-1];
            assign x_in   = c_x_reg[s-1];
            assign ovf_in = c_ovf_reg[s-1];
        end

        always_comb
        begin
            csel = ({1'b0, n_eff} > (TERMS_W+1)'(J)) ? $signed(coef[J]) : '0;
            sum  = {t_in[VAL_W-1], t_in} + {csel[VAL_W-1], csel};
            rs   = (b_p_reg[s] + HALF) >>> FRAC_BITS;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_t_reg[s]   <= sum[VAL_W-1:0];
                a_x_reg[s]   <= x_in;
                a_ovf_reg[s] <= ovf_in | (sum[VAL_W] != sum[VAL_W-1]);
                b_p_reg[s]   <= a_t_reg[s] * a_x_reg[s];
                b_x_reg[s]   <= a_x_reg[s];
                b_ovf_reg[s] <= a_ovf_reg[s];
                c_t_reg[s]   <= rs[VAL_W-1:0];
                c_x_reg[s]   <= b_x_reg[s];
                c_ovf_reg[s] <= b_ovf_reg[s]
                                | (rs[2*VAL_W-1:VAL_W-1] != {(VAL_W+1){rs[VAL_W-1]}});
            end
        end
    end

    logic signed [VAL_W-1:0] c0;
    logic signed [VAL_W:0]   fsum;

    always_comb
    begin
        c0   = $signed(coef[0]);
        fsum = {c_t_reg[STEPS-1][VAL_W-1], c_t_reg[STEPS-1]} + {c0[VAL_W-1], c0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= (n_eff == '0) ? ONE : fsum[VAL_W-1:0];
            ovf_reg <= (n_eff != '0)
                       && (c_ovf_reg[STEPS-1] || (fsum[VAL_W] != fsum[VAL_W-1]));
        end
    end

    assign val = val_reg;
    assign ovf = ovf_reg;
endmodule
`default_nettype wire

/* src/rfe_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rfe_div
    import rfe_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)(
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [VAL_W-1:0]                at,
    input  wire logic [VAL_W-1:0]                ab,
    output logic [FRAC_BITS+LIMIT_W:0]           q2
);
    localparam int QW = FRAC_BITS + LIMIT_W + 1;

    logic [VAL_W-1:0] rem_reg [QW];
    logic [QW-1:0]    q_reg   [QW];
    logic [VAL_W-1:0] at_reg  [QW];
    logic [VAL_W-1:0] ab_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int I = QW - 1 - k;
        logic [VAL_W-1:0] rem_in;
        logic [QW-1:0]    q_in;
        logic [VAL_W-1:0] at_in;
        logic [VAL_W-1:0] ab_in;
        logic             bitv;
        logic [VAL_W:0]   r2;
        logic [VAL_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = at >> LIMIT_W;
            assign q_in   = '0;
            assign at_in  = at;
            assign ab_in  = ab;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign at_in  = at_reg[k-1];
            assign ab_in  = ab_reg[k-1];
        end

        if (I >= FRAC_BITS + 1) begin : g_data
            assign bitv = at_in[I-FRAC_BITS-1];
        end
        else begin : g_zero
            assign bitv = 1'b0;
        end

        always_comb
        begin
            r2   = {rem_in, bitv};
            diff = r2 - {1'b0, ab_in};
            ge   = (r2 >= {1'b0, ab_in});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[VAL_W-1:0] : r2[VAL_W-1:0];
                q_reg[k]   <= {q_in[QW-2:0], ge};
                at_reg[k]  <= at_in;
                ab_reg[k]  <= ab_in;
            end
        end
    end

    assign q2 = q_reg[QW-1];
endmodule
`default_nettype wire

/* src/rational_function_evaluator_unit.sv */
// Rational function evaluator: ratio = P(x) / Q(x), signed fixed point.
// Input channel in_valid/in_ready carries x_value and x_missing; output
// channel out_valid/out_ready carries ratio_value, ratio_missing and
// status_code. Coefficients and term counts are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the pipeline
// is empty, since the block itself does not enforce it. The pipeline has
// one input register, seven Horner stages for both polynomials in
// parallel, three stages for sign handling and the range check, one
// restoring-division stage per quotient bit, and the output register.
// Throughput is one item per cycle unless the output stalls; the division
// stages set the depth. The whole pipeline advances together: when
// out_valid is high and out_ready is low, every stage holds and in_ready
// drops, so no transfer is lost or repeated. Bubbles advance with the data.
// Reset clears all valid bits and configuration registers (term counts zero,
// so both polynomials read as one); no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_function_evaluator_unit_defines.svh"
module rational_function_evaluator_unit
    import rfe_pkg::*;
#(
    parameter int MAX_TERMS   = DEF_MAX_TERMS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int RATIO_LIMIT = DEF_RATIO_LIMIT
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [VAL_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [VAL_W-1:0] x_value,
    input  wire logic                    x_missing,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [VAL_W-1:0]      ratio_value,
    output logic                         ratio_missing,
    output logic [2:0]                   status_code
);
    localparam int EFF   = (MAX_TERMS < COEF_REGS) ? MAX_TERMS : COEF_REGS;
    localparam int HL    = 3 * (COEF_REGS - 1) + 1;
    localparam int QW    = FRAC_BITS + LIMIT_W + 1;
    localparam int TOT   = 1 + HL + 3 + QW + 1;
    localparam int PW    = VAL_W + LIMIT_W;

    logic [TERMS_W-1:0] num_terms_reg;
    logic [TERMS_W-1:0] den_terms_reg;
    coef_vec_t          num_coef_reg;
    coef_vec_t          den_coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_terms_reg <= '0;
            den_terms_reg <= '0;
            num_coef_reg  <= '0;
            den_coef_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_NUM_TERMS: num_terms_reg   <= cfg_data[TERMS_W-1:0];
                REG_DEN_TERMS: den_terms_reg   <= cfg_data[TERMS_W-1:0];
                REG_NUM_C0:    num_coef_reg[0] <= cfg_data;
                REG_NUM_C1:    num_coef_reg[1] <= cfg_data;
                REG_NUM_C2:    num_coef_reg[2] <= cfg_data;
                REG_DEN_C0:    den_coef_reg[0] <= cfg_data;
                REG_DEN_C1:    den_coef_reg[1] <= cfg_data;
                REG_DEN_C2:    den_coef_reg[2] <= cfg_data;
                default:       num_terms_reg   <= num_terms_reg;
            endcase
        end
    end

    logic [TERMS_W-1:0] num_n;
    logic [TERMS_W-1:0] den_n;

    assign num_n = (num_terms_reg > TERMS_W'(EFF)) ? TERMS_W'(EFF) : num_terms_reg;
    assign den_n = (den_terms_reg > TERMS_W'(EFF)) ? TERMS_W'(EFF) : den_terms_reg;

    logic           en;
    logic [TOT-1:0] v_reg;

    assign en        = !v_reg[TOT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[TOT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[TOT-2:0], in_valid};
    end

    logic signed [VAL_W-1:0] x_reg;
    logic                    miss_reg;
    logic                    miss_line_reg [HL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_value;
            miss_reg <= x_missing;
            miss_line_reg[0] <= miss_reg;
            for (int i = 1; i < HL; i++)
                miss_line_reg[i] <= miss_line_reg[i-1];
        end
    end

    logic signed [VAL_W-1:0] top;
    logic signed [VAL_W-1:0] bot;
    logic                    top_ovf;
    logic                    bot_ovf;

    rfe_horner #(.FRAC_BITS(FRAC_BITS)) u_num (
        .clk   (clk),
        .en    (en),
        .x     (x_reg),
        .coef  (num_coef_reg),
        .n_eff (num_n),
        .val   (top),
        .ovf   (top_ovf)
    );

    rfe_horner #(.FRAC_BITS(FRAC_BITS)) u_den (
        .clk   (clk),
        .en    (en),
        .x     (x_reg),
        .coef  (den_coef_reg),
        .n_eff (den_n),
        .val   (bot),
        .ovf   (bot_ovf)
    );

    side_t            cmb_next;
    side_t            cmb_reg;
    logic [VAL_W-1:0] at_reg;
    logic [VAL_W-1:0] ab_reg;

    always_comb
    begin
        cmb_next = '{done: 1'b0, missing: 1'b0, status: ST_OK,
                     neg: (top[VAL_W-1] != bot[VAL_W-1])};
        if (miss_line_reg[HL-1])
            cmb_next = '{done: 1'b1, missing: 1'b1, status: ST_MISSING, neg: 1'b0};
        else if (top_ovf)
            cmb_next = '{done: 1'b1, missing: 1'b1, status: ST_LARGE, neg: 1'b0};
        else if (bot_ovf)
            cmb_next = '{done: 1'b1, missing: 1'b0, status: ST_OK, neg: 1'b0};
        else if (bot == '0)
            cmb_next = '{done: 1'b1, missing: 1'b1,
                         status: (top != '0) ? ST_POLE : ST_ZERO_ZERO, neg: 1'b0};
    end

    side_t            lp_side_reg;
    logic [PW-1:0]    lp_reg;
    logic [VAL_W-1:0] lp_at_reg;
    logic [VAL_W-1:0] lp_ab_reg;
    side_t            chk_next;
    side_t            chk_reg;
    logic [VAL_W-1:0] chk_at_reg;
    logic [VAL_W-1:0] chk_ab_reg;

    always_comb
    begin
        chk_next = lp_side_reg;
        if (!lp_side_reg.done && ({{LIMIT_W{1'b0}}, lp_at_reg} > lp_reg))
            chk_next = '{done: 1'b1, missing: 1'b1, status: ST_LARGE, neg: 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmb_reg     <= cmb_next;
            at_reg      <= top[VAL_W-1] ? VAL_W'(0) - top : top;
            ab_reg      <= bot[VAL_W-1] ? VAL_W'(0) - bot : bot;
            lp_side_reg <= cmb_reg;
            lp_reg      <= PW'(ab_reg) * PW'(RATIO_LIMIT);
            lp_at_reg   <= at_reg;
            lp_ab_reg   <= ab_reg;
            chk_reg     <= chk_next;
            chk_at_reg  <= lp_at_reg;
            chk_ab_reg  <= lp_ab_reg;
        end
    end

    logic [QW-1:0] q2;
    side_t         side_line_reg [QW];

    rfe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk (clk),
        .en  (en),
        .at  (chk_at_reg),
        .ab  (chk_ab_reg),
        .q2  (q2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_line_reg[0] <= chk_reg;
            for (int i = 1; i < QW; i++)
                side_line_reg[i] <= side_line_reg[i-1];
        end
    end

    side_t                   fin;
    logic [2*VAL_W-1:0]      qx;
    logic [2*VAL_W-1:0]      qr;
    logic signed [VAL_W-1:0] val_next;
    logic                    miss_next;
    status_t                 st_next;
    logic signed [VAL_W-1:0] val_reg;
    logic                    rmiss_reg;
    status_t                 st_reg;

    always_comb
    begin
        fin       = side_line_reg[QW-1];
        qx        = (2*VAL_W)'(q2) + (2*VAL_W)'(1);
        qr        = qx >> 1;
        val_next  = '0;
        miss_next = fin.missing;
        st_next   = fin.status;
        if (!fin.done)
        begin
            if (qr[2*VAL_W-1:VAL_W-1] != '0)
            begin
                miss_next = 1'b1;
                st_next   = ST_LARGE;
            end
            else
                val_next = fin.neg ? VAL_W'(0) - qr[VAL_W-1:0] : qr[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg   <= val_next;
            rmiss_reg <= miss_next;
            st_reg    <= st_next;
        end
    end

    assign ratio_value   = val_reg;
    assign ratio_missing = rmiss_reg;
    assign status_code   = st_reg;

    `RFE_ASSERT_IMPLY(a_missing_zero, clk, rst_n, out_valid && ratio_missing,
        ratio_value == '0)
    `RFE_ASSERT_IMPLY(a_status_flag, clk, rst_n, out_valid,
        ratio_missing == (status_code != ST_OK))
    `RFE_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(val_reg) && $stable(st_reg))
endmodule
`default_nettype wire

/* tb/rfe_checker.sv */
`timescale 1ns / 1ps
module rfe_checker
    import rfe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [VAL_W-1:0]        cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic signed [VAL_W-1:0] x_value,
    input  logic                    x_missing,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [VAL_W-1:0] ratio_value,
    input  logic                    ratio_missing,
    input  logic [2:0]              status_code,
    output int                      errors,
    output int                      pending
);
    typedef struct {
        logic [VAL_W-1:0] value;
        logic             missing;
        status_t          status;
    } ratio_result_t;

    localparam longint V_MAX = 64'sd2147483647;
    localparam longint V_MIN = -64'sd2147483648;

    logic [TERMS_W-1:0] num_count;
    logic [TERMS_W-1:0] den_count;
    longint             num_c[COEF_REGS];
    longint             den_c[COEF_REGS];
    ratio_result_t      ratio_fifo[$];

    assign pending = ratio_fifo.size();

    function automatic bit horner_overflows(input longint c[COEF_REGS], input int terms,
                                            input longint x, output longint v);
        longint acc;
        acc = 0;
        v = 0;
        if (terms == 0)
        begin
            v = longint'(1) <<< DEF_FRAC_BITS;
            return 0;
        end
        for (int j = terms - 1; j > 0; j--)
        begin
            acc += c[j];
            if (acc > V_MAX || acc < V_MIN)
                return 1;
            acc = (acc * x + (longint'(1) <<< (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
            if (acc > V_MAX || acc < V_MIN)
                return 1;
        end
        acc += c[0];
        if (acc > V_MAX || acc < V_MIN)
            return 1;
        v = acc;
        return 0;
    endfunction

    function automatic ratio_result_t predict_ratio(input logic signed [VAL_W-1:0] xv,
                                                    input logic xm);
        ratio_result_t r;
        longint top, bot, x;
        longint unsigned at, ab, q;
        r.value = '0;
        r.missing = 1'b1;
        r.status = ST_OK;
        x = xv;
        if (xm)
            r.status = ST_MISSING;
        else if (horner_overflows(num_c, num_count, x, top))
            r.status = ST_LARGE;
        else if (horner_overflows(den_c, den_count, x, bot))
            r.missing = 1'b0;
        else if (bot == 0)
            r.status = (top != 0) ? ST_POLE : ST_ZERO_ZERO;
        else
        begin
            at = (top < 0) ? -top : top;
            ab = (bot < 0) ? -bot : bot;
            if (at > ab * DEF_RATIO_LIMIT)
                r.status = ST_LARGE;
            else
            begin
                q = (((at << (DEF_FRAC_BITS + 1)) / ab) + 1) >> 1;
                if (q > V_MAX)
                    r.status = ST_LARGE;
                else
                begin
                    r.missing = 1'b0;
                    r.value = ((top < 0) != (bot < 0)) ? -q : q;
                end
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [VAL_W-1:0] got,
                          input logic [VAL_W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        ratio_result_t want;
        if (!rst_n)
        begin
            num_count <= '0;
            den_count <= '0;
            for (int i = 0; i < COEF_REGS; i++)
            begin
                num_c[i] = 0;
                den_c[i] = 0;
            end
            ratio_fifo.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_NUM_TERMS: num_count <= cfg_data[TERMS_W-1:0];
                    REG_DEN_TERMS: den_count <= cfg_data[TERMS_W-1:0];
                    REG_NUM_C0:    num_c[0] = longint'(signed'(cfg_data));
                    REG_NUM_C1:    num_c[1] = longint'(signed'(cfg_data));
                    REG_NUM_C2:    num_c[2] = longint'(signed'(cfg_data));
                    REG_DEN_C0:    den_c[0] = longint'(signed'(cfg_data));
                    REG_DEN_C1:    den_c[1] = longint'(signed'(cfg_data));
                    REG_DEN_C2:    den_c[2] = longint'(signed'(cfg_data));
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                ratio_fifo.push_back(predict_ratio(x_value, x_missing));
            if (out_valid && out_ready)
            begin
                if (ratio_fifo.size() == 0)
                    report("unexpected transfer", ratio_value, '0);
                else
                begin
                    want = ratio_fifo.pop_front();
                    if (ratio_value !== want.value)
                        report("ratio_value", ratio_value, want.value);
                    if (ratio_missing !== want.missing)
                        report("ratio_missing", ratio_missing, want.missing);
                    if (status_code !== want.status)
                        report("status_code", status_code, want.status);
                end
            end
        end
    end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import rfe_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [VAL_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [VAL_W-1:0] x_value = '0;
    logic                    x_missing = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [VAL_W-1:0] ratio_value;
    logic                    ratio_missing;
    logic [2:0]              status_code;
    int                      errors;
    int                      pending;
    bit                      bursty = 1'b1;
    int                      hold_cnt = 0;
    int                      quiet_cycles = 0;

    always #5 clk = ~clk;

    rational_function_evaluator_unit i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .x_value(x_value), .x_missing(x_missing), .out_valid(out_valid),
        .out_ready(out_ready), .ratio_value(ratio_value),
        .ratio_missing(ratio_missing), .status_code(status_code)
    );

    rfe_checker i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .x_value(x_value), .x_missing(x_missing), .out_valid(out_valid),
        .out_ready(out_ready), .ratio_value(ratio_value),
        .ratio_missing(ratio_missing), .status_code(status_code),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (bursty && $urandom_range(0, 7) == 0)
        begin
            hold_cnt <= $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [VAL_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_ratio_cfg(input int nt, input int dt,
                                  input logic [VAL_W-1:0] n0, n1, n2, d0, d1, d2);
        write_reg(REG_NUM_TERMS, nt);
        write_reg(REG_DEN_TERMS, dt);
        write_reg(REG_NUM_C0, n0);
        write_reg(REG_NUM_C1, n1);
        write_reg(REG_NUM_C2, n2);
        write_reg(REG_DEN_C0, d0);
        write_reg(REG_DEN_C1, d1);
        write_reg(REG_DEN_C2, d2);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [VAL_W-1:0] xv, input logic xm);
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_value <= xv;
        x_missing <= xm;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input bit allow_zero);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: case ($urandom_range(0, 4))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'hffff_ffff;
                   3: return 32'h0001_0000;
                   default: return allow_zero ? 32'h0 : 32'h0000_0001;
               endcase
            2: return allow_zero ? 32'h0 : 32'hfffe_0000;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    initial
    begin
        int phases;
        phases = 20;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(32'h0, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        drain();
        load_ratio_cfg(1, 1, 32'h7fff_ffff, 0, 0, 32'h1, 0, 0);
        send_sample(32'h0, 1'b0);
        drain();
        load_ratio_cfg(1, 1, 32'h0005_0000, 0, 0, 0, 0, 0);
        send_sample(32'h1234_5678, 1'b0);
        drain();
        load_ratio_cfg(1, 1, 0, 0, 0, 0, 0, 0);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'h0001_0000, 1'b1);
        drain();
        load_ratio_cfg(3, 3, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_8000, 1'b0);
        drain();
        load_ratio_cfg(0, 3, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h0, 1'b0);
        drain();
        load_ratio_cfg(2, 2, 32'h0003_0000, 32'hffff_0000, 0,
                       32'h0002_0000, 32'h0001_0000, 0);
        send_sample(32'h0001_8000, 1'b0);
        send_sample(32'hfffe_0000, 1'b0);
        send_sample(32'hfffe_8000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        drain();

        for (int p = 0; p < phases; p++)
        begin
            bursty = (p < phases - 2) && (p % 5 != 3);
            load_ratio_cfg($urandom_range(0, 3), $urandom_range(0, 3),
                           pick_value(1), pick_value(1), pick_value(1),
                           pick_value($urandom_range(0, 3) == 0), pick_value(1),
                           pick_value(1));
            repeat (80)
                send_sample(pick_value(1), $urandom_range(0, 9) == 0);
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
